@@ design/slpg_pkg.sv @@
package slpg_pkg;

   localparam int BREATHE_PERIOD_MS = 2000;

   localparam int CMD_WIDTH      = 1;
   localparam int CODE_WIDTH     = 16;
   localparam int TIME_WIDTH     = 32;
   localparam int COLOUR_WIDTH   = 8;
   localparam int LEVEL_WIDTH    = 5;
   localparam int PHASE_WIDTH    = $clog2(BREATHE_PERIOD_MS);
   localparam int PRODUCT_WIDTH  = 2 * TIME_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RECORDING_CODE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UPLOADING_CODE = 1'd1;

   localparam logic [CODE_WIDTH-1:0] RECORDING_CODE_RESET = 16'd500;
   localparam logic [CODE_WIDTH-1:0] UPLOADING_CODE_RESET = 16'd100;

   localparam logic [CMD_WIDTH-1:0] CMD_NORMAL = 1'b0;
   localparam logic [CMD_WIDTH-1:0] CMD_FAULT  = 1'b1;

   localparam logic [TIME_WIDTH-1:0] UPLOAD_BLINK_MS = 32'd100;
   localparam logic [TIME_WIDTH-1:0] BREATHE_STEP_MS = 32'd30;

   localparam logic [COLOUR_WIDTH-1:0] SOLID_RED_LEVEL    = 8'd30;
   localparam logic [COLOUR_WIDTH-1:0] FAULT_RED_LEVEL    = 8'd255;
   localparam logic [COLOUR_WIDTH-1:0] UPLOAD_GREEN_LEVEL = 8'd30;

   localparam logic [TIME_WIDTH-1:0] PERIOD_RECIP =
      32'((64'd1 << 32) / BREATHE_PERIOD_MS);

   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] BREATHE_BASE = 64'd3;
   localparam logic [63:0] BREATHE_SPAN = 64'd25;

   typedef struct packed {
      logic mult;
      logic reduce;
      logic lookup;
   } stage_advance_type;

   typedef logic [LEVEL_WIDTH-1:0] level_table_type [BREATHE_PERIOD_MS];

   function automatic logic signed [63:0] quarter_sine(input logic [63:0] frac);
      logic [63:0]        theta;
      logic [63:0]        th2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      if (frac >= ONE_Q30) begin
         return $signed(ONE_Q30);
      end
      theta = (frac * HALF_PI_Q30) >> 30;
      th2   = (theta * theta) >> 30;
      term  = theta;
      sum   = $signed(theta);
      for (int n = 1; n <= 5; n++) begin
         term = (term * th2) >> 30;
         case (n)
            1: begin
               term = term / 64'd6;
            end
            2: begin
               term = term / 64'd20;
            end
            3: begin
               term = term / 64'd42;
            end
            4: begin
               term = term / 64'd72;
            end
            default: begin
               term = term / 64'd110;
            end
         endcase
         if ((n % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      if (sum < 0) begin
         sum = 0;
      end
      return sum;
   endfunction

   function automatic level_table_type build_level_table();
      level_table_type    levels;
      logic [63:0]        q;
      logic [63:0]        quad;
      logic [63:0]        r;
      logic [63:0]        num;
      logic [63:0]        level;
      logic signed [63:0] s;
      for (int p = 0; p < BREATHE_PERIOD_MS; p++) begin
         q    = 64'(4 * p);
         quad = q / BREATHE_PERIOD_MS;
         r    = q - quad * BREATHE_PERIOD_MS;
         num  = quad[0] ? (64'(BREATHE_PERIOD_MS) - r) : r;
         s    = quarter_sine((num << 30) / BREATHE_PERIOD_MS);
         if (quad >= 64'd2) begin
            s = -s;
         end
         level = (BREATHE_SPAN * 64'($signed(ONE_Q30) + s)) >> 31;
         levels[p] = LEVEL_WIDTH'(BREATHE_BASE + level);
      end
      return levels;
   endfunction

   localparam level_table_type LEVEL_TABLE = build_level_table();

endpackage

@@ design/slpg_breathe.sv @@
module slpg_breathe (
   input  logic                                   clock,
   input  slpg_pkg::stage_advance_type            advance,
   input  logic                                   breathe,
   input  logic [slpg_pkg::TIME_WIDTH-1:0]        now_ms,
   output logic [slpg_pkg::COLOUR_WIDTH-1:0]      blue
);

   logic [slpg_pkg::PRODUCT_WIDTH-1:0] product_ff, product_in;
   logic [slpg_pkg::TIME_WIDTH-1:0]    time_ff;
   logic                               breathe_mult_ff;
   logic [slpg_pkg::PHASE_WIDTH-1:0]   phase_ff, phase_in;
   logic                               breathe_reduce_ff;
   logic [slpg_pkg::COLOUR_WIDTH-1:0]  blue_ff;
   logic [slpg_pkg::TIME_WIDTH-1:0]    quotient;
   logic [slpg_pkg::TIME_WIDTH-1:0]    remainder;

   // The reciprocal estimate is at most one below the true quotient, so the
   // remainder lies below twice the period and one subtraction corrects it.
   assign product_in = now_ms * slpg_pkg::PERIOD_RECIP;

   always_comb begin
      quotient  = product_ff[slpg_pkg::PRODUCT_WIDTH-1:slpg_pkg::TIME_WIDTH];
      remainder = time_ff - slpg_pkg::TIME_WIDTH'(quotient *
                  slpg_pkg::TIME_WIDTH'(slpg_pkg::BREATHE_PERIOD_MS));
      if (remainder >= slpg_pkg::TIME_WIDTH'(slpg_pkg::BREATHE_PERIOD_MS)) begin
         remainder = remainder - slpg_pkg::TIME_WIDTH'(slpg_pkg::BREATHE_PERIOD_MS);
      end
      phase_in = remainder[slpg_pkg::PHASE_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance.mult) begin
         product_ff      <= product_in;
         time_ff         <= now_ms;
         breathe_mult_ff <= breathe;
      end
      if (advance.reduce) begin
         phase_ff          <= phase_in;
         breathe_reduce_ff <= breathe_mult_ff;
      end
      if (advance.lookup) begin
         if (breathe_reduce_ff) begin
            blue_ff <= slpg_pkg::COLOUR_WIDTH'(slpg_pkg::LEVEL_TABLE[phase_ff]);
         end else begin
            blue_ff <= '0;
         end
      end
   end

   assign blue = blue_ff;

endmodule

@@ design/status_led_pattern_generator.sv @@
// Status LED pattern generator. Each item on the request stream is one tick
// carrying the millisecond time, a command (normal or fault) and an interval
// code; each tick yields exactly one result item with a write flag and an
// RGB colour, which is all zeros when nothing is written. In normal mode a
// code equal to the recording register gives solid red, a code equal to the
// uploading register blinks green every 100 ms, and any other code gives a
// blue breathe refreshed every 30 ms; fault mode blinks red after the given
// interval. The block takes one item every cycle while rsp_tready does not
// hold back the result stream: the pattern decision and timing state are
// settled as the item is taken, then the breathe phase passes through a
// reciprocal multiply, a remainder correction and a registered read of the
// breathe level ROM. The configuration registers should be written only
// while no item is in flight.
module status_led_pattern_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // interval_ms[15:0], now_ms[47:16]
   input  logic [0:0]  req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic [0:0]  rsp_tuser,   // led_write[0]
   input  logic        csr_we,
   input  logic [slpg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [slpg_pkg::CODE_WIDTH-1:0]      csr_data
);

   logic [slpg_pkg::CODE_WIDTH-1:0]   recording_code_ff;
   logic [slpg_pkg::CODE_WIDTH-1:0]   uploading_code_ff;
   logic [slpg_pkg::TIME_WIDTH-1:0]   last_update_ff, last_update_in;
   logic                              toggle_phase_ff, toggle_phase_in;

   logic                              valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic                              write1_ff, write2_ff, write3_ff, write4_ff;
   logic [slpg_pkg::COLOUR_WIDTH-1:0] red1_ff, red2_ff, red3_ff, red4_ff;
   logic [slpg_pkg::COLOUR_WIDTH-1:0] green1_ff, green2_ff, green3_ff, green4_ff;
   logic                              breathe1_ff;
   logic [slpg_pkg::TIME_WIDTH-1:0]   now1_ff;

   logic                              write_in, breathe_in;
   logic [slpg_pkg::COLOUR_WIDTH-1:0] red_in, green_in;

   logic                              cmd;
   logic [slpg_pkg::CODE_WIDTH-1:0]   code;
   logic [slpg_pkg::TIME_WIDTH-1:0]   now_ms;
   logic [slpg_pkg::TIME_WIDTH-1:0]   elapsed;
   logic                              accept;
   logic                              advance1, advance2, advance3, advance4;
   slpg_pkg::stage_advance_type       advance;
   logic [slpg_pkg::COLOUR_WIDTH-1:0] blue;

   assign cmd    = req_tuser[0];
   assign code   = req_tdata[15:0];
   assign now_ms = req_tdata[47:16];

   assign advance4   = !valid4_ff || rsp_tready;
   assign advance3   = !valid3_ff || advance4;
   assign advance2   = !valid2_ff || advance3;
   assign advance1   = !valid1_ff || advance2;
   assign req_tready = advance1 && !reset;
   assign accept     = req_tvalid && req_tready;

   assign advance.mult   = advance2;
   assign advance.reduce = advance3;
   assign advance.lookup = advance4;

   assign elapsed = now_ms - last_update_ff;

   always_comb begin
      last_update_in  = last_update_ff;
      toggle_phase_in = toggle_phase_ff;
      write_in        = 1'b0;
      red_in          = '0;
      green_in        = '0;
      breathe_in      = 1'b0;
      if (cmd == slpg_pkg::CMD_FAULT) begin
         if (elapsed >= slpg_pkg::TIME_WIDTH'(code)) begin
            last_update_in  = now_ms;
            toggle_phase_in = !toggle_phase_ff;
            write_in        = 1'b1;
            red_in          = toggle_phase_in ? slpg_pkg::FAULT_RED_LEVEL : '0;
         end
      end else if (code == recording_code_ff) begin
         write_in = 1'b1;
         red_in   = slpg_pkg::SOLID_RED_LEVEL;
      end else if (code == uploading_code_ff) begin
         if (elapsed >= slpg_pkg::UPLOAD_BLINK_MS) begin
            last_update_in  = now_ms;
            toggle_phase_in = !toggle_phase_ff;
            write_in        = 1'b1;
            green_in        = toggle_phase_in ? slpg_pkg::UPLOAD_GREEN_LEVEL : '0;
         end
      end else if (elapsed >= slpg_pkg::BREATHE_STEP_MS) begin
         last_update_in = now_ms;
         write_in       = 1'b1;
         breathe_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recording_code_ff <= slpg_pkg::RECORDING_CODE_RESET;
         uploading_code_ff <= slpg_pkg::UPLOADING_CODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            slpg_pkg::REG_RECORDING_CODE: begin
               recording_code_ff <= csr_data;
            end
            slpg_pkg::REG_UPLOADING_CODE: begin
               uploading_code_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_update_ff  <= '0;
         toggle_phase_ff <= 1'b0;
         valid1_ff       <= 1'b0;
         valid2_ff       <= 1'b0;
         valid3_ff       <= 1'b0;
         valid4_ff       <= 1'b0;
      end else begin
         if (accept) begin
            last_update_ff  <= last_update_in;
            toggle_phase_ff <= toggle_phase_in;
         end
         if (advance1) begin
            valid1_ff <= req_tvalid;
         end
         if (advance2) begin
            valid2_ff <= valid1_ff;
         end
         if (advance3) begin
            valid3_ff <= valid2_ff;
         end
         if (advance4) begin
            valid4_ff <= valid3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance1) begin
         write1_ff   <= write_in;
         red1_ff     <= red_in;
         green1_ff   <= green_in;
         breathe1_ff <= breathe_in;
         now1_ff     <= now_ms;
      end
      if (advance2) begin
         write2_ff <= write1_ff;
         red2_ff   <= red1_ff;
         green2_ff <= green1_ff;
      end
      if (advance3) begin
         write3_ff <= write2_ff;
         red3_ff   <= red2_ff;
         green3_ff <= green2_ff;
      end
      if (advance4) begin
         write4_ff <= write3_ff;
         red4_ff   <= red3_ff;
         green4_ff <= green3_ff;
      end
   end

   slpg_breathe u_breathe (
      .clock   (clock),
      .advance (advance),
      .breathe (breathe1_ff),
      .now_ms  (now1_ff),
      .blue    (blue)
   );

   assign rsp_tvalid = valid4_ff;
   assign rsp_tdata  = {blue, green4_ff, red4_ff};
   assign rsp_tuser  = write4_ff;

endmodule
